// File: sv/mvna_pkg.sv
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared types, constants and codes of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

    // vertex store geometry (depth is a power of two, index wraps by masking)
    localparam int VIDX_W   = 10;
    localparam int VERTICES = 1 << VIDX_W;

    localparam int COORD_W = 32;                  // Q16.16 coordinate
    localparam int SUM_W   = 32;                  // saturating normal sum
    localparam int CNT_W   = 16;                  // saturating use count
    localparam int VEC_W   = 33;                  // unit-scaler input component
    localparam int NRM_W   = 16;                  // Q1.14 unit component
    localparam int CRS_W   = 18;                  // rounded cross component

    typedef logic [VIDX_W-1:0] vidx_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // queued command word
    typedef struct packed {
        op_t                        op;
        vidx_t                      a;
        vidx_t                      b;
        vidx_t                      c;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } cmd_t;

    // back end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
        logic [CNT_W-1:0]        cnt;
    } acc_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } nrm_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_SQ,
        U_ROOT,
        U_DSET,
        U_DIV,
        U_DONE
    } unit_state_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_VWR,
        S_RDA,
        S_RDB,
        S_RDC,
        S_E1,
        S_U1,
        S_E2,
        S_U2,
        S_X,
        S_ACC_RD,
        S_ACC_WR,
        S_SRD,
        S_SCHK,
        S_SU,
        S_OUT
    } back_state_t;

endpackage

// File: sv/mvna_req_if.sv
// ----------------------------------------------------------------------------
// mvna_req_if
// Command channel: vertex writes, triangles and normal reads.
// ----------------------------------------------------------------------------
interface mvna_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [9:0]         first_index;
    logic [9:0]         second_index;
    logic [9:0]         third_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (
        output valid, opcode, first_index, second_index, third_index,
               coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_index, second_index, third_index,
               coord_x, coord_y, coord_z,
        output ready
    );
endinterface

// File: sv/mvna_rsp_if.sv
// ----------------------------------------------------------------------------
// mvna_rsp_if
// Result channel: one unit normal word per read command.
// ----------------------------------------------------------------------------
interface mvna_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_valid;

    modport source (
        output valid, normal_x, normal_y, normal_z, normal_valid,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, normal_valid,
        output ready
    );
endinterface

// File: sv/mesh_vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator_top
// Per-vertex normals of a triangle mesh, accumulated from triangle commands.
// After reset the block clears its 1024-entry accumulator memory, one entry
// per cycle, and holds req.ready low until that pass is over. Triangles and
// normal reads wait in the back end on the shared unit-length scaler (a
// 32-step square root and three 15-step divisions per vector), used twice
// per triangle and once per read of a touched vertex. A two-word queue lets
// commands be taken while the back end works and while a result waits on
// rsp.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator_top
    import mvna_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mvna_req_if.sink    req,
    mvna_rsp_if.source  rsp
);

    logic       cmd_valid;
    cmd_t       cmd;
    back_ctl_t  ctl;

    mvna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    mvna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ctl       (ctl),
        .rsp       (rsp)
    );

endmodule

// File: sv/mvna_front.sv
// ----------------------------------------------------------------------------
// mvna_front
// Accepts command words, drops the unused opcode and queues the rest
// in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module mvna_front
    import mvna_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    mvna_req_if.sink        req,
    input  back_ctl_t       ctl,
    output logic            cmd_valid,
    output cmd_t            cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       word;

    // classify incoming word
    always_comb
    begin
        word.op = op_t'(req.opcode);
        word.a  = vidx_t'(req.first_index);
        word.b  = vidx_t'(req.second_index);
        word.c  = vidx_t'(req.third_index);
        word.x  = req.coord_x;
        word.y  = req.coord_y;
        word.z  = req.coord_z;
    end

    assign req.ready = (count_reg != 2'd2) && !ctl.clearing;
    assign push      = req.valid && req.ready && (word.op != OP_NONE);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ ctl.pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, ctl.pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

// File: sv/mvna_unit.sv
// ----------------------------------------------------------------------------
// mvna_unit
// Scales a three-component vector to unit length in Q1.14: squares on one
// multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module mvna_unit
    import mvna_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  vec_t    vin,
    output logic    done,
    output nrm_t    vout
);

    localparam int MAG_W = 31;
    localparam int SQ_W  = 64;
    localparam int LEN_W = 32;
    localparam int Q_W   = 15;
    localparam int NUM_W = MAG_W + 15;

    unit_state_t        state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg [3];
    logic [2:0]         neg_reg;
    logic [2*MAG_W-1:0] prod_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [LEN_W+2:0]   rem_reg;
    logic [LEN_W-1:0]   root_reg;
    logic [4:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic [LEN_W-1:0]   drem_reg;
    logic [Q_W-1:0]     lo_reg;
    logic [Q_W-1:0]     quo_reg;
    logic signed [NRM_W-1:0] res_reg [3];

    logic [VEC_W-1:0]   m_in [3];
    logic [1:0]         shamt;
    logic [1:0]         sel;
    logic [MAG_W-1:0]   mag_sel;
    logic               neg_sel;
    logic [LEN_W+2:0]   rem_sh;
    logic [LEN_W+2:0]   trial;
    logic               root_bit;
    logic [NUM_W-1:0]   num;
    logic [LEN_W:0]     drem_sh;
    logic               q_bit;
    logic [Q_W-1:0]     q_final;
    logic signed [NRM_W-1:0] q_signed;

    // magnitudes of the incoming components and the pre-shift
    always_comb
    begin
        m_in[0] = VEC_W'((VEC_W+1)'(vin.x[VEC_W-1] ? -(VEC_W+1)'(vin.x) : (VEC_W+1)'(vin.x)));
        m_in[1] = VEC_W'((VEC_W+1)'(vin.y[VEC_W-1] ? -(VEC_W+1)'(vin.y) : (VEC_W+1)'(vin.y)));
        m_in[2] = VEC_W'((VEC_W+1)'(vin.z[VEC_W-1] ? -(VEC_W+1)'(vin.z) : (VEC_W+1)'(vin.z)));
        if (m_in[0][VEC_W-1] || m_in[1][VEC_W-1] || m_in[2][VEC_W-1])
            shamt = 2'd2;
        else if (m_in[0][VEC_W-2] || m_in[1][VEC_W-2] || m_in[2][VEC_W-2])
            shamt = 2'd1;
        else
            shamt = 2'd0;
    end

    // one component select shared by squaring and division
    assign sel     = (state_reg == U_SQ) ? cnt_reg[1:0] : comp_reg;
    assign mag_sel = mag_reg[sel];
    assign neg_sel = neg_reg[sel];

    // root step
    always_comb
    begin
        rem_sh   = {rem_reg[LEN_W:0], sq_reg[SQ_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        root_bit = (rem_sh >= trial);
    end

    // divider setup and step: (mag * 16384 + len / 2) / len
    always_comb
    begin
        num      = NUM_W'({mag_sel, 14'd0}) + NUM_W'(root_reg >> 1);
        drem_sh  = {drem_reg, lo_reg[Q_W-1]};
        q_bit    = (drem_sh >= {1'b0, root_reg});
        q_final  = (root_reg == '0) ? '0 : {quo_reg[Q_W-2:0], q_bit};
        q_signed = neg_sel ? -NRM_W'(q_final) : NRM_W'(q_final);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: if (start) state_next = U_SQ;
            U_SQ:   if (cnt_reg == 5'd3) state_next = U_ROOT;
            U_ROOT: if (cnt_reg == 5'd31) state_next = U_DSET;
            U_DSET: state_next = U_DIV;
            U_DIV:
                if (cnt_reg == 5'(Q_W-1))
                    state_next = (comp_reg == 2'd2) ? U_DONE : U_DSET;
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done   = (state_reg == U_DONE);
        vout.x = res_reg[0];
        vout.y = res_reg[1];
        vout.z = res_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= MAG_W'(m_in[i] >> shamt);
                neg_reg  <= {vin.z[VEC_W-1], vin.y[VEC_W-1], vin.x[VEC_W-1]};
                cnt_reg  <= '0;
                sq_reg   <= '0;
            end
            U_SQ:
            begin
                if (cnt_reg != 5'd3)
                    prod_reg <= mag_sel * mag_sel;
                if (cnt_reg != 5'd0)
                    sq_reg <= sq_reg + SQ_W'(prod_reg);
                cnt_reg  <= (cnt_reg == 5'd3) ? '0 : cnt_reg + 5'd1;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            U_ROOT:
            begin
                rem_reg  <= root_bit ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[LEN_W-2:0], root_bit};
                sq_reg   <= sq_reg << 2;
                cnt_reg  <= cnt_reg + 5'd1;
                comp_reg <= 2'd0;
            end
            U_DSET:
            begin
                drem_reg <= LEN_W'(num >> Q_W);
                lo_reg   <= num[Q_W-1:0];
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            U_DIV:
            begin
                drem_reg <= q_bit ? LEN_W'(drem_sh - {1'b0, root_reg}) : LEN_W'(drem_sh);
                lo_reg   <= lo_reg << 1;
                quo_reg  <= {quo_reg[Q_W-2:0], q_bit};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(Q_W-1))
                begin
                    res_reg[comp_reg] <= q_signed;
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/mvna_back.sv
// ----------------------------------------------------------------------------
// mvna_back
// Command sequencer: vertex and accumulator memories, triangle normal,
// saturating accumulation, read-out through an output register.
// ----------------------------------------------------------------------------
module mvna_back
    import mvna_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output back_ctl_t   ctl,
    mvna_rsp_if.source  rsp
);

    back_state_t             state_reg, state_next;
    cmd_t                    cmd_reg;
    vidx_t                   clr_reg;
    vtx_t                    va_reg, vb_reg, vc_reg;
    nrm_t                    p_reg, q_reg;
    logic [2:0]              xcnt_reg;
    logic signed [31:0]      prod_reg, diff_reg;
    logic signed [CRS_W-1:0] n_reg [3];
    logic [1:0]              k_reg;

    vtx_t                    vmem [VERTICES];
    acc_t                    smem [VERTICES];
    vtx_t                    vrd_reg;
    acc_t                    srd_reg;

    nrm_t                    res_nrm_reg;
    logic                    res_nv_reg;
    logic                    rsp_valid_reg;
    nrm_t                    rsp_nrm_reg;
    logic                    rsp_nv_reg;

    logic                    unit_start, unit_done;
    vec_t                    unit_in;
    nrm_t                    unit_out;

    vidx_t                   vraddr, sraddr, swaddr, corner;
    logic                    vwe, swe, out_free;
    acc_t                    swdata, acc_new;
    logic signed [15:0]      op_a, op_b;

    function automatic logic signed [CRS_W-1:0] round14(input logic signed [31:0] d);
        logic [31:0]       mag;
        logic [CRS_W-1:0]  r;
        mag = d[31] ? 32'(-d) : 32'(d);
        r   = CRS_W'((mag + 32'd8192) >> 14);
        return d[31] ? -r : r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                        input logic signed [CRS_W-1:0] n);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
        if (t[SUM_W] != t[SUM_W-1])
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return t[SUM_W-1:0];
    endfunction

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign corner   = (k_reg == 2'd0) ? cmd_reg.a : (k_reg == 2'd1) ? cmd_reg.b : cmd_reg.c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == vidx_t'(VERTICES-1)) state_next = S_IDLE;
            S_IDLE:
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_WRITE: state_next = S_VWR;
                        OP_TRI:   state_next = S_RDA;
                        OP_READ:  state_next = S_SRD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            S_VWR:    state_next = S_IDLE;
            S_RDA:    state_next = S_RDB;
            S_RDB:    state_next = S_RDC;
            S_RDC:    state_next = S_E1;
            S_E1:     state_next = S_U1;
            S_U1:     if (unit_done) state_next = S_E2;
            S_E2:     state_next = S_U2;
            S_U2:     if (unit_done) state_next = S_X;
            S_X:      if (xcnt_reg == 3'd6) state_next = S_ACC_RD;
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: state_next = (k_reg == 2'd2) ? S_IDLE : S_ACC_RD;
            S_SRD:    state_next = S_SCHK;
            S_SCHK:   state_next = (srd_reg.cnt == '0) ? S_OUT : S_SU;
            S_SU:     if (unit_done) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control outputs and memory port selection
    always_comb
    begin
        ctl.pop      = (state_reg == S_IDLE) && cmd_valid;
        ctl.clearing = (state_reg == S_CLEAR);

        vwe    = (state_reg == S_VWR);
        vraddr = (state_reg == S_RDA) ? cmd_reg.a :
                 (state_reg == S_RDB) ? cmd_reg.b : cmd_reg.c;
        sraddr = (state_reg == S_SRD) ? cmd_reg.a : corner;

        acc_new.x   = sat_add(srd_reg.x, n_reg[0]);
        acc_new.y   = sat_add(srd_reg.y, n_reg[1]);
        acc_new.z   = sat_add(srd_reg.z, n_reg[2]);
        acc_new.cnt = (srd_reg.cnt == '1) ? srd_reg.cnt : srd_reg.cnt + CNT_W'(1);

        swe    = (state_reg == S_CLEAR) || (state_reg == S_VWR) || (state_reg == S_ACC_WR);
        swaddr = (state_reg == S_CLEAR) ? clr_reg :
                 (state_reg == S_VWR)   ? cmd_reg.a : corner;
        swdata = (state_reg == S_ACC_WR) ? acc_new : '0;

        unit_start = (state_reg == S_E1) || (state_reg == S_E2) ||
                     ((state_reg == S_SCHK) && (srd_reg.cnt != '0));
        if (state_reg == S_E1)
        begin
            unit_in.x = VEC_W'(vb_reg.x) - VEC_W'(va_reg.x);
            unit_in.y = VEC_W'(vb_reg.y) - VEC_W'(va_reg.y);
            unit_in.z = VEC_W'(vb_reg.z) - VEC_W'(va_reg.z);
        end
        else if (state_reg == S_E2)
        begin
            unit_in.x = VEC_W'(vc_reg.x) - VEC_W'(va_reg.x);
            unit_in.y = VEC_W'(vc_reg.y) - VEC_W'(va_reg.y);
            unit_in.z = VEC_W'(vc_reg.z) - VEC_W'(va_reg.z);
        end
        else
        begin
            unit_in.x = VEC_W'(srd_reg.x);
            unit_in.y = VEC_W'(srd_reg.y);
            unit_in.z = VEC_W'(srd_reg.z);
        end

        // cross product operand order: yz, zy, zx, xz, xy, yx
        case (xcnt_reg)
            3'd0:    begin op_a = p_reg.y; op_b = q_reg.z; end
            3'd1:    begin op_a = p_reg.z; op_b = q_reg.y; end
            3'd2:    begin op_a = p_reg.z; op_b = q_reg.x; end
            3'd3:    begin op_a = p_reg.x; op_b = q_reg.z; end
            3'd4:    begin op_a = p_reg.x; op_b = q_reg.y; end
            default: begin op_a = p_reg.y; op_b = q_reg.x; end
        endcase
    end

    mvna_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .vin   (unit_in),
        .done  (unit_done),
        .vout  (unit_out)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[cmd_reg.a] <= '{x: cmd_reg.x, y: cmd_reg.y, z: cmd_reg.z};
        vrd_reg <= vmem[vraddr];
        if (swe)
            smem[swaddr] <= swdata;
        srd_reg <= smem[sraddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + vidx_t'(1);
            if ((state_reg == S_OUT) && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.pop)
            cmd_reg <= cmd;
        if (state_reg == S_RDB)
            va_reg <= vrd_reg;
        if (state_reg == S_RDC)
            vb_reg <= vrd_reg;
        if (state_reg == S_E1)
            vc_reg <= vrd_reg;
        if ((state_reg == S_U1) && unit_done)
            p_reg <= unit_out;
        if ((state_reg == S_U2) && unit_done)
        begin
            q_reg    <= unit_out;
            xcnt_reg <= '0;
        end
        if (state_reg == S_X)
        begin
            prod_reg <= op_a * op_b;
            xcnt_reg <= xcnt_reg + 3'd1;
            case (xcnt_reg)
                3'd1, 3'd3, 3'd5: diff_reg <= prod_reg;
                3'd2:             n_reg[0] <= round14(diff_reg - prod_reg);
                3'd4:             n_reg[1] <= round14(diff_reg - prod_reg);
                3'd6:             n_reg[2] <= round14(diff_reg - prod_reg);
                default:          ;
            endcase
            k_reg <= 2'd0;
        end
        if (state_reg == S_ACC_WR)
            k_reg <= k_reg + 2'd1;
        // result is staged here so a word still waiting on rsp stays intact
        if (state_reg == S_SCHK)
        begin
            res_nrm_reg <= '0;
            res_nv_reg  <= (srd_reg.cnt != '0);
        end
        if ((state_reg == S_SU) && unit_done)
            res_nrm_reg <= unit_out;
        if ((state_reg == S_OUT) && out_free)
        begin
            rsp_nrm_reg <= res_nrm_reg;
            rsp_nv_reg  <= res_nv_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.normal_x     = rsp_nrm_reg.x;
    assign rsp.normal_y     = rsp_nrm_reg.y;
    assign rsp.normal_z     = rsp_nrm_reg.z;
    assign rsp.normal_valid = rsp_nv_reg;

    // no command leaves the queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !ctl.pop)
        else $error("command popped during clearing pass");

    // the scaler only finishes while the sequencer waits on it
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> ((state_reg == S_U1) || (state_reg == S_U2) || (state_reg == S_SU)))
        else $error("scaler done outside a wait state");

    // an untouched vertex reads back as a zero vector
    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_nv_reg) |->
            ((rsp_nrm_reg.x == '0) && (rsp_nrm_reg.y == '0) && (rsp_nrm_reg.z == '0)))
        else $error("untouched vertex returned a nonzero normal");

    // a result is loaded only when the output register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free) |=> rsp_valid_reg)
        else $error("result word lost");

endmodule
